@@ hw/rtl/bmm_pkg.sv @@
package bmm_pkg;

    // default number of 4K windows in the cpu space
    localparam int WINDOW_COUNT_DEF = 16;

    // field widths
    localparam int FUNC_W = 3;
    localparam int ADDR_W = 16;
    localparam int DATA_W = 8;
    localparam int OFF_W  = 12;
    localparam int MODE_W = 4;

    // map register value that reset loads (rom page 7)
    localparam logic [DATA_W-1:0] MAP_RESET = 8'hFF;

    // plane index of the final beat of a plane copy
    localparam logic [1:0] PLANE_LAST = 2'd2;

    // upper address nibbles of the three colour planes
    localparam logic [3:0] PLANE0_HI = 4'h6;
    localparam logic [3:0] PLANE1_HI = 4'hA;
    localparam logic [3:0] PLANE2_HI = 4'hE;

    // video mode bit that selects plane copy
    localparam int MODE_COPY_BIT = 3;

    // operation codes of an input transaction
    typedef enum logic [FUNC_W-1:0] {
        FUNC_CPU_READ   = 3'd0,
        FUNC_CPU_WRITE  = 3'd1,
        FUNC_MAP_WRITE  = 3'd2,
        FUNC_MAP_READ   = 3'd3,
        FUNC_MODE_WRITE = 3'd4
    } func_t;

    // destination of a result
    typedef enum logic [1:0] {
        TGT_NONE = 2'd0,
        TGT_RAM  = 2'd1,
        TGT_ROM  = 2'd2,
        TGT_REG  = 2'd3
    } target_t;

    // one result beat
    typedef struct packed {
        target_t             target;
        logic [ADDR_W-1:0]   phys_addr;
        logic                write_enable;
        logic [DATA_W-1:0]   write_data;
        logic [DATA_W-1:0]   read_data;
        logic                last;
    } result_t;

    // state update requests from the translator
    typedef struct packed {
        logic map_we;
        logic mode_we;
    } upd_t;

endpackage

@@ hw/rtl/bmm_map_regs.sv @@
module bmm_map_regs #(
    parameter int WINDOW_COUNT = bmm_pkg::WINDOW_COUNT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  bmm_pkg::upd_t                     upd,
    input  logic [$clog2(WINDOW_COUNT)-1:0]   wr_idx,
    input  logic [bmm_pkg::DATA_W-1:0]        wr_data,
    input  logic [$clog2(WINDOW_COUNT)-1:0]   rd_idx,
    output logic [bmm_pkg::DATA_W-1:0]        rd_data,
    output logic [bmm_pkg::MODE_W-1:0]        video_mode
);
    import bmm_pkg::*;

    logic [DATA_W-1:0] map_reg [WINDOW_COUNT];
    logic [MODE_W-1:0] mode_reg;

    // window mapping registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_COUNT; i++) begin
                map_reg[i] <= MAP_RESET;
            end
        end else if (upd.map_we) begin
            map_reg[wr_idx] <= wr_data;
        end
    end

    // video mode register keeps the low nibble
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= '0;
        end else if (upd.mode_we) begin
            mode_reg <= wr_data[MODE_W-1:0];
        end
    end

    assign rd_data    = map_reg[rd_idx];
    assign video_mode = mode_reg;

endmodule

@@ hw/rtl/bmm_translate.sv @@
module bmm_translate (
    input  logic [bmm_pkg::FUNC_W-1:0]  func,
    input  logic [bmm_pkg::ADDR_W-1:0]  cpu_address,
    input  logic [bmm_pkg::DATA_W-1:0]  cpu_data,
    input  logic [bmm_pkg::DATA_W-1:0]  map_val,
    input  logic [bmm_pkg::MODE_W-1:0]  video_mode,
    input  logic [1:0]                  plane,
    output bmm_pkg::result_t            res,
    output bmm_pkg::upd_t               upd
);
    import bmm_pkg::*;

    logic [OFF_W-1:0] off;
    logic             is_ram;
    logic             is_rom;
    logic             is_video;
    logic             copy;
    logic [3:0]       plane_hi;
    logic             plane_en;

    assign off    = cpu_address[OFF_W-1:0];
    assign is_ram = (map_val[7:4] == 4'hE);
    assign is_rom = (map_val[7:3] == 5'b11111);

    // video pages e6/e7/ea/eb/ee/ef
    always_comb begin
        case (map_val[3:0])
            4'h6, 4'h7, 4'hA, 4'hB, 4'hE, 4'hF: is_video = is_ram;
            default:                            is_video = 1'b0;
        endcase
    end

    assign copy = is_video && video_mode[MODE_COPY_BIT];

    // plane base nibble and enable for the current beat
    always_comb begin
        case (plane)
            2'd0: begin
                plane_hi = PLANE0_HI;
                plane_en = video_mode[0];
            end
            2'd1: begin
                plane_hi = PLANE1_HI;
                plane_en = video_mode[1];
            end
            default: begin
                plane_hi = PLANE2_HI;
                plane_en = video_mode[2];
            end
        endcase
    end

    // operation decode
    always_comb begin
        res        = '0;
        res.target = TGT_NONE;
        res.last   = 1'b1;
        upd        = '0;
        unique case (func)
            FUNC_CPU_READ: begin
                if (is_ram) begin
                    res.target    = TGT_RAM;
                    res.phys_addr = {map_val[3:0], off};
                end else if (is_rom) begin
                    res.target    = TGT_ROM;
                    res.phys_addr = {1'b0, map_val[2:0], off};
                end
            end
            FUNC_CPU_WRITE: begin
                if (copy) begin
                    res.target       = TGT_RAM;
                    res.phys_addr    = {plane_hi | {3'b000, map_val[0]}, off};
                    res.write_enable = 1'b1;
                    res.write_data   = plane_en ? cpu_data : '0;
                    res.last         = (plane == PLANE_LAST);
                end else if (is_ram) begin
                    res.target       = TGT_RAM;
                    res.phys_addr    = {map_val[3:0], off};
                    res.write_enable = 1'b1;
                    res.write_data   = cpu_data;
                end
            end
            FUNC_MAP_WRITE: begin
                upd.map_we = 1'b1;
            end
            FUNC_MAP_READ: begin
                res.target    = TGT_REG;
                res.read_data = map_val;
            end
            FUNC_MODE_WRITE: begin
                upd.mode_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

@@ hw/rtl/banked_memory_mapper_with_plane_copy.sv @@
// Banked memory mapper with colour-plane copy.
//
// Input stream (s_*): one cpu bus access per transaction. s_tuser carries the
// operation code, s_tdata the address and data. Output stream (m_*): the
// translated memory access; m_tlast marks the final result of an access.
//
// Each access is held in an input register, translated by a map register
// lookup and a compare, and lands in an output register driving m_tvalid.
// One transaction is accepted per cycle while s_tready is high. A cpu
// write to a video page in copy mode gives three results, one per cycle
// with m_tready high, and holds the input register until the third moves on.
//
// When the receiver stalls, the output register holds its result and the
// input register holds the next access; s_tready drops once both are full.
// Reset (aresetn low, synchronous) empties both registers, sets every
// window map register to 0xFF (rom page 7) and clears the video mode.
module banked_memory_mapper_with_plane_copy #(
    parameter int WINDOW_COUNT = bmm_pkg::WINDOW_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] cpu_address, [23:16] cpu_data
    input  logic [2:0]  s_tuser,   // [2:0] func
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [15:0] phys_addr, [16] write_enable,
                                   // [24:17] write_data, [32:25] read_data
    output logic [1:0]  m_tuser,   // [1:0] target
    output logic        m_tlast
);
    import bmm_pkg::*;

    localparam int IDX_W = $clog2(WINDOW_COUNT);

    logic              in_valid_reg;
    logic [FUNC_W-1:0] in_func_reg;
    logic [ADDR_W-1:0] in_addr_reg;
    logic [DATA_W-1:0] in_data_reg;
    logic [1:0]        plane_reg;
    logic              out_valid_reg;
    result_t           out_reg;

    logic              out_free;
    logic              advance;
    logic              done;
    logic [IDX_W-1:0]  rd_idx;
    logic [DATA_W-1:0] map_val;
    logic [MODE_W-1:0] video_mode;
    result_t           res;
    upd_t              upd_req;
    upd_t              upd;

    // handshake and flow control
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign done     = advance && res.last;
    assign s_tready = !in_valid_reg || done;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_func_reg <= s_tuser;
            in_addr_reg <= s_tdata[15:0];
            in_data_reg <= s_tdata[23:16];
        end
    end

    // plane counter for copy-mode beats
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_reg <= '0;
        end else if (advance) begin
            plane_reg <= res.last ? 2'd0 : plane_reg + 2'd1;
        end
    end

    // map register select: register index for readback, window otherwise
    assign rd_idx = (in_func_reg == FUNC_MAP_READ) ? in_addr_reg[IDX_W-1:0]
                                                  : in_addr_reg[OFF_W +: IDX_W];

    // state updates take effect when the access moves on
    assign upd.map_we  = upd_req.map_we && advance;
    assign upd.mode_we = upd_req.mode_we && advance;

    bmm_map_regs #(
        .WINDOW_COUNT(WINDOW_COUNT)
    ) u_map_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .upd        (upd),
        .wr_idx     (in_addr_reg[IDX_W-1:0]),
        .wr_data    (in_data_reg),
        .rd_idx     (rd_idx),
        .rd_data    (map_val),
        .video_mode (video_mode)
    );

    bmm_translate u_translate (
        .func        (in_func_reg),
        .cpu_address (in_addr_reg),
        .cpu_data    (in_data_reg),
        .map_val     (map_val),
        .video_mode  (video_mode),
        .plane       (plane_reg),
        .res         (res),
        .upd         (upd_req)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.read_data, out_reg.write_data,
                       out_reg.write_enable, out_reg.phys_addr};
    assign m_tuser  = out_reg.target;
    assign m_tlast  = out_reg.last;

endmodule

@@ sim/bmm_access_checker.sv @@
module bmm_access_checker #(
    parameter int WINDOW_COUNT = bmm_pkg::WINDOW_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] cpu_address, [23:16] cpu_data
    input  logic [2:0]  s_tuser,   // [2:0] func
    // result stream
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // [15:0] phys_addr, [16] write_enable,
                                   // [24:17] write_data, [32:25] read_data
    input  logic [1:0]  m_tuser,   // [1:0] target
    input  logic        m_tlast,
    output int unsigned mismatch_count,
    output int unsigned beats_pending
);
    import bmm_pkg::*;

    // map register ranges
    localparam logic [DATA_W-1:0] RAM_FIRST = 8'hE0;
    localparam logic [DATA_W-1:0] RAM_LAST  = 8'hEF;
    localparam logic [DATA_W-1:0] ROM_FIRST = 8'hF8;
    localparam int                REG_W     = $clog2(WINDOW_COUNT);

    // shadow copy of the mapper state
    logic [DATA_W-1:0] window_map [WINDOW_COUNT];
    logic [MODE_W-1:0] video_mode;

    // translated accesses still to come out of the block, oldest first
    result_t expected_beats [$];

    task automatic report_mismatch(input string what, input logic [41:0] got,
                                   input logic [41:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic result_t make_beat(input target_t tgt, input logic [ADDR_W-1:0] addr,
                                          input logic we, input logic [DATA_W-1:0] wd,
                                          input logic [DATA_W-1:0] rd, input logic lst);
        result_t b;
        b.target       = tgt;
        b.phys_addr    = addr;
        b.write_enable = we;
        b.write_data   = wd;
        b.read_data    = rd;
        b.last         = lst;
        return b;
    endfunction

    function automatic logic is_video_page(input logic [DATA_W-1:0] v);
        return v == 8'hE6 || v == 8'hE7 || v == 8'hEA ||
               v == 8'hEB || v == 8'hEE || v == 8'hEF;
    endfunction

    // work out the results of one access and update the shadow state
    task automatic translate_access(input logic [FUNC_W-1:0] func,
                                    input logic [ADDR_W-1:0] addr,
                                    input logic [DATA_W-1:0] data);
        logic [3:0]        win;
        logic [OFF_W-1:0]  off;
        logic [REG_W-1:0]  sel;
        logic [DATA_W-1:0] v;
        logic              ram;
        logic              rom;
        logic [3:0]        hi;
        int                p;
        win = addr[ADDR_W-1:OFF_W];
        off = addr[OFF_W-1:0];
        sel = addr[REG_W-1:0];
        v   = window_map[win];
        ram = (v >= RAM_FIRST) && (v <= RAM_LAST);
        rom = (v >= ROM_FIRST);
        case (func)
            FUNC_CPU_READ: begin
                if (ram)
                    expected_beats.push_back(make_beat(TGT_RAM, {v[3:0], off}, 1'b0, '0, '0, 1'b1));
                else if (rom)
                    expected_beats.push_back(make_beat(TGT_ROM, {v[3:0] - 4'd8, off}, 1'b0,
                                                       '0, '0, 1'b1));
                else
                    expected_beats.push_back(make_beat(TGT_NONE, '0, 1'b0, '0, '0, 1'b1));
            end
            FUNC_CPU_WRITE: begin
                if (!ram) begin
                    // rom or unmapped: the write is dropped
                    expected_beats.push_back(make_beat(TGT_NONE, '0, 1'b0, '0, '0, 1'b1));
                end else if (is_video_page(v) && video_mode[MODE_COPY_BIT]) begin
                    // plane copy: one beat per colour plane, odd page one 4K higher
                    for (p = 0; p < 3; p++) begin
                        hi = (p == 0) ? PLANE0_HI : (p == 1) ? PLANE1_HI : PLANE2_HI;
                        expected_beats.push_back(make_beat(TGT_RAM, {hi | {3'b000, v[0]}, off},
                                                           1'b1, video_mode[p] ? data : '0, '0,
                                                           p == PLANE_LAST));
                    end
                end else begin
                    expected_beats.push_back(make_beat(TGT_RAM, {v[3:0], off}, 1'b1, data,
                                                       '0, 1'b1));
                end
            end
            FUNC_MAP_WRITE: begin
                window_map[sel] = data;
                expected_beats.push_back(make_beat(TGT_NONE, '0, 1'b0, '0, '0, 1'b1));
            end
            FUNC_MAP_READ: begin
                expected_beats.push_back(make_beat(TGT_REG, '0, 1'b0, '0, window_map[sel], 1'b1));
            end
            FUNC_MODE_WRITE: begin
                video_mode = data[MODE_W-1:0];
                expected_beats.push_back(make_beat(TGT_NONE, '0, 1'b0, '0, '0, 1'b1));
            end
            default: begin
                expected_beats.push_back(make_beat(TGT_NONE, '0, 1'b0, '0, '0, 1'b1));
            end
        endcase
    endtask

    // compare the result transaction on the bus with the oldest expectation
    task automatic check_result();
        result_t want;
        if (expected_beats.size() == 0) begin
            report_mismatch("result with nothing expected", {m_tuser, m_tdata}, '0);
            return;
        end
        want = expected_beats.pop_front();
        if (m_tuser !== want.target)
            report_mismatch("target", m_tuser, want.target);
        if (m_tdata[15:0] !== want.phys_addr)
            report_mismatch("phys_addr", m_tdata[15:0], want.phys_addr);
        if (m_tdata[16] !== want.write_enable)
            report_mismatch("write_enable", m_tdata[16], want.write_enable);
        if (m_tdata[24:17] !== want.write_data)
            report_mismatch("write_data", m_tdata[24:17], want.write_data);
        if (m_tdata[32:25] !== want.read_data)
            report_mismatch("read_data", m_tdata[32:25], want.read_data);
        if (m_tdata[39:33] !== '0)
            report_mismatch("tdata padding", m_tdata[39:33], '0);
        if (m_tlast !== want.last)
            report_mismatch("last", m_tlast, want.last);
    endtask

    // watch both channels; results always belong to earlier accesses
    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (window_map[i]) window_map[i] = MAP_RESET;
            video_mode     = '0;
            mismatch_count = 0;
            expected_beats.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
                translate_access(s_tuser, s_tdata[15:0], s_tdata[23:16]);
        end
        beats_pending = expected_beats.size();
    end

endmodule

@@ sim/banked_memory_mapper_with_plane_copy_test.sv @@
module banked_memory_mapper_with_plane_copy_test;
    import bmm_pkg::*;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;    // [15:0] cpu_address, [23:16] cpu_data
    logic [2:0]  s_tuser  = '0;    // [2:0] func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // [15:0] phys_addr, [16] write_enable,
                                   // [24:17] write_data, [32:25] read_data
    logic [1:0]  m_tuser;          // [1:0] target
    logic        m_tlast;

    int unsigned mismatch_count;
    int unsigned beats_pending;
    int unsigned accepted_count = 0;
    logic        hold_off       = 1'b0;
    logic        sender_gaps    = 1'b1;

    logic [DATA_W-1:0] video_pages [6] = '{8'hE6, 8'hE7, 8'hEA, 8'hEB, 8'hEE, 8'hEF};

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    banked_memory_mapper_with_plane_copy dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    bmm_access_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .beats_pending  (beats_pending)
    );

    // mostly back to back or short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!sender_gaps || hold_off)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // map values weighted toward ram and video pages
    function automatic logic [DATA_W-1:0] pick_map_value();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return video_pages[$urandom_range(0, 5)];
        else if (r < 6)
            return 8'(8'hE0 + $urandom_range(0, 15));
        else if (r < 8)
            return 8'(8'hF8 + $urandom_range(0, 7));
        return 8'($urandom_range(0, 255));
    endfunction

    // offer one access and wait until the block takes the transaction
    task automatic send_access(input logic [FUNC_W-1:0] func, input logic [ADDR_W-1:0] addr,
                               input logic [DATA_W-1:0] data);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {data, addr};
        do @(posedge aclk); while (!s_tready);
        accepted_count++;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // result side: random ready with stalls and steady stretches
    initial begin : sink
        int unsigned stall;
        int unsigned steady;
        int unsigned r;
        stall  = 0;
        steady = 0;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
            end else if (steady != 0) begin
                m_tready <= 1'b1;
                steady--;
            end else if (stall != 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    steady = $urandom_range(20, 60);
                else if (r < 8)
                    stall = $urandom_range(10, 40);
                else if (r < 30)
                    stall = $urandom_range(1, 3);
                m_tready <= (r < 4) || (r >= 30);
            end
        end
    end

    // long receiver hold-off so the block fills and stalls its input
    initial begin : pressure
        wait (accepted_count >= 60);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (250) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin : stimulus
        int unsigned       sent;
        int unsigned       r;
        logic [FUNC_W-1:0] f;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset contents: every window reads rom page 7, writes there are dropped
        send_access(FUNC_MAP_READ, 16'h0000, 8'h00);
        send_access(FUNC_CPU_READ, 16'h0FFF, 8'h00);
        send_access(FUNC_CPU_WRITE, 16'h0123, 8'hFF);
        // value just below the ram range leaves the window unmapped
        send_access(FUNC_MAP_WRITE, 16'hFFFF, 8'hDF);
        send_access(FUNC_CPU_READ, 16'hF000, 8'h00);
        send_access(FUNC_CPU_WRITE, 16'hFFFF, 8'hFF);
        // ram page 0 and rom page 0
        send_access(FUNC_MAP_WRITE, 16'h0001, 8'hE0);
        send_access(FUNC_CPU_READ, 16'h1000, 8'h00);
        send_access(FUNC_CPU_WRITE, 16'h1FFF, 8'hAA);
        send_access(FUNC_MAP_WRITE, 16'h0004, 8'hF8);
        send_access(FUNC_CPU_READ, 16'h4FFF, 8'h00);
        // value just below the rom range, then read back through high address bits
        send_access(FUNC_MAP_WRITE, 16'h0006, 8'hF7);
        send_access(FUNC_CPU_WRITE, 16'h6AAA, 8'h55);
        send_access(FUNC_MAP_READ, 16'hFFF6, 8'h00);
        // video page outside copy mode is a plain write; mode keeps only its low bits
        send_access(FUNC_MAP_WRITE, 16'h0002, 8'hEF);
        send_access(FUNC_MODE_WRITE, 16'h0000, 8'hF0);
        send_access(FUNC_CPU_WRITE, 16'h2000, 8'h55);
        // copy mode, planes 0 and 2 on, odd page
        send_access(FUNC_MODE_WRITE, 16'h0000, 8'h0D);
        send_access(FUNC_CPU_WRITE, 16'h2ABC, 8'hFF);
        // even video page with all planes, then copy with no plane enabled
        send_access(FUNC_MAP_WRITE, 16'h0003, 8'hE6);
        send_access(FUNC_MODE_WRITE, 16'hFFFF, 8'hFF);
        send_access(FUNC_CPU_WRITE, 16'h3000, 8'h81);
        send_access(FUNC_MODE_WRITE, 16'h0000, 8'h08);
        send_access(FUNC_CPU_WRITE, 16'h3FFF, 8'h7E);
        // non-video ram page stays a single write in copy mode
        send_access(FUNC_CPU_WRITE, 16'h1234, 8'h3C);
        // undefined operation codes
        for (int unsigned k = 5; k < 8; k++)
            send_access(3'(k), 16'hFFFF, 8'hFF);

        // random accesses, sender gaps switched per stretch
        sent = 0;
        while (sent < 150) begin
            if (sent % 30 == 0)
                sender_gaps = ($urandom_range(0, 3) != 0);
            r    = $urandom_range(0, 99);
            addr = 16'($urandom_range(0, 16'hFFFF));
            data = 8'($urandom_range(0, 8'hFF));
            if (r < 38) begin
                f = FUNC_CPU_WRITE;
            end else if (r < 62) begin
                f = FUNC_CPU_READ;
            end else if (r < 80) begin
                f    = FUNC_MAP_WRITE;
                data = pick_map_value();
            end else if (r < 88) begin
                f = FUNC_MAP_READ;
            end else if (r < 96) begin
                f = FUNC_MODE_WRITE;
            end else begin
                f = 3'($urandom_range(5, 7));
            end
            send_access(f, addr, data);
            if (f <= FUNC_MODE_WRITE)
                sent++;
        end
        s_tvalid <= 1'b0;

        // drain, then a few more cycles to catch stray results
        do @(negedge aclk); while (beats_pending != 0);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // run limit
    initial begin : watchdog
        #3000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
